[design/cfpm_pkg.sv]
// Shared types, codes and helpers for the capture frame pool manager.
package cfpm_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int LINK_W     = $clog2(NUM_FRAMES + 1);
    localparam int SEQ_W      = 32;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_FRAMES);

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_STOP    = 3'd1;
    localparam logic [2:0] KIND_CAPTURE = 3'd2;
    localparam logic [2:0] KIND_TAKE    = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_FILLED   = 2'd1;
    localparam logic [1:0] ST_NOT_RUNNING = 2'd2;
    localparam logic [1:0] ST_NO_FRAME    = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] frame_index;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       out_frame;
        logic [SEQ_W-1:0] out_sequence;
        logic             overwrote_oldest;
        logic             is_running;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APPEND,
        S_WALK_RD,
        S_WALK_WR,
        S_POP_RD,
        S_POP_WB,
        S_SEQ_WB
    } t_state;

    typedef struct packed {
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
        logic               link_we;
        logic [FRAME_W-1:0] link_addr;
        logic [LINK_W-1:0]  link_data;
        logic               seq_we;
        logic [FRAME_W-1:0] seq_addr;
        logic [SEQ_W-1:0]   seq_data;
    } t_store_req;

    function automatic logic is_frame(input logic [LINK_W-1:0] l);
        return l < NIL_LINK;
    endfunction

    function automatic logic [FRAME_W-1:0] addr_of(input logic [LINK_W-1:0] l);
        logic [LINK_W+FRAME_W-1:0] w;
        w = (LINK_W + FRAME_W)'(l);
        return w[FRAME_W-1:0];
    endfunction

    function automatic logic [2:0] out_frame_of(input logic [LINK_W-1:0] l);
        logic [LINK_W+2:0] w;
        w = (LINK_W + 3)'(l);
        return w[2:0];
    endfunction

    function automatic logic [LINK_W-1:0] link_of_index(input logic [2:0] x);
        logic [LINK_W+2:0] w;
        w = (LINK_W + 3)'(x);
        return w[LINK_W-1:0];
    endfunction

    function automatic logic index_in_pool(input logic [2:0] x);
        return (LINK_W + 3)'(x) < (LINK_W + 3)'(NUM_FRAMES);
    endfunction

endpackage

[design/cfpm_store.sv]
// Link and sequence-number stores: registered synchronous reads, link reset by valid bits.
module cfpm_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfpm_pkg::t_store_req       i_req,
    output logic [cfpm_pkg::LINK_W-1:0] o_link,
    output logic [cfpm_pkg::SEQ_W-1:0]  o_seq
);
    import cfpm_pkg::*;

    logic [LINK_W-1:0]     link_mem [NUM_FRAMES];
    logic [SEQ_W-1:0]      seq_mem  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] r_link_valid;
    logic [LINK_W-1:0]     r_link_q;
    logic [SEQ_W-1:0]      r_seq_q;
    logic [FRAME_W-1:0]    r_rd_addr;
    logic                  r_rd_valid;

    // Reset chain of the free list: each frame points to the one below it.
    function automatic logic [LINK_W-1:0] reset_link(input logic [FRAME_W-1:0] a);
        if (a == '0) begin
            return NIL_LINK;
        end
        return LINK_W'(a) - LINK_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_req.link_we) begin
            link_mem[i_req.link_addr] <= i_req.link_data;
        end
        if (i_req.seq_we) begin
            seq_mem[i_req.seq_addr] <= i_req.seq_data;
        end
        if (i_req.rd_en) begin
            r_link_q  <= link_mem[i_req.rd_addr];
            r_seq_q   <= seq_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_req.link_we) begin
                r_link_valid[i_req.link_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_link_valid[i_req.rd_addr];
            end
        end
    end

    assign o_link = r_rd_valid ? r_link_q : reset_link(r_rd_addr);
    assign o_seq  = r_seq_q;

endmodule

[design/capture_frame_pool_manager_core.sv]
// Top level of the capture frame pool manager: event sequencer around the link store.
//
// A command transfer is taken when start is high and busy is low; every command gives
// exactly one result, shown on o_res for a single cycle with o_done high, and the
// receiver cannot stall it. Stop, release, unknown kinds and rejected take or capture
// commands finish in the execute state; take pops the filled list (link read, then
// write-back); capture terminates the finished frame, chains it behind an existing
// tail if any, then pops a new target; start while running reads the target's sequence
// number, if any; start while stopped returns the stale target and every filled frame
// to the free list, then pops a new target, or is refused when the consumer holds every
// frame. Pops and walk steps wait for their link reads on the single read port of the
// link store. The result appears in the cycle in which busy falls again, so a new
// command may be issued alongside it. After reset the pool is ready at once.
module capture_frame_pool_manager_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  cfpm_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_done,
    output cfpm_pkg::t_res o_res
);
    import cfpm_pkg::*;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [LINK_W-1:0]     r_free_head, n_free_head;
    logic [LINK_W-1:0]     r_filled_head, n_filled_head;
    logic [LINK_W-1:0]     r_filled_tail, n_filled_tail;
    logic [LINK_W-1:0]     r_target, n_target;
    logic [SEQ_W-1:0]      r_seq_cnt, n_seq_cnt;
    logic                  r_running, n_running;
    logic [NUM_FRAMES-1:0] r_held, n_held;
    logic [LINK_W-1:0]     r_cursor, n_cursor;
    logic [LINK_W-1:0]     r_walk_cnt, n_walk_cnt;
    logic                  r_pop_filled, n_pop_filled;
    logic                  r_pop_take, n_pop_take;
    logic                  r_done, n_done;
    t_res                  r_res, n_res;

    t_store_req            store_req;
    logic [LINK_W-1:0]     rd_link;
    logic [SEQ_W-1:0]      rd_seq;
    logic                  pop_from_filled;
    logic [LINK_W-1:0]     pop_frame;
    logic [LINK_W-1:0]     rel_frame;

    cfpm_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_link  (rd_link),
        .o_seq   (rd_seq)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_head   <= LINK_W'(NUM_FRAMES - 1);
            r_filled_head <= NIL_LINK;
            r_filled_tail <= NIL_LINK;
            r_target      <= NIL_LINK;
            r_seq_cnt     <= '0;
            r_running     <= 1'b0;
            r_held        <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_head   <= n_free_head;
            r_filled_head <= n_filled_head;
            r_filled_tail <= n_filled_tail;
            r_target      <= n_target;
            r_seq_cnt     <= n_seq_cnt;
            r_running     <= n_running;
            r_held        <= n_held;
            r_done        <= n_done;
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cursor     <= n_cursor;
        r_walk_cnt   <= n_walk_cnt;
        r_pop_filled <= n_pop_filled;
        r_pop_take   <= n_pop_take;
        r_res        <= n_res;
    end

    // Take pops the filled list; a capture pop falls back to it only when no frame is free.
    assign pop_from_filled = r_pop_take || !is_frame(r_free_head);
    assign pop_frame       = pop_from_filled ? r_filled_head : r_free_head;
    assign rel_frame       = link_of_index(r_cmd.frame_index);

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_free_head   = r_free_head;
        n_filled_head = r_filled_head;
        n_filled_tail = r_filled_tail;
        n_target      = r_target;
        n_seq_cnt     = r_seq_cnt;
        n_running     = r_running;
        n_held        = r_held;
        n_cursor      = r_cursor;
        n_walk_cnt    = r_walk_cnt;
        n_pop_filled  = r_pop_filled;
        n_pop_take    = r_pop_take;
        n_done        = 1'b0;
        n_res         = r_res;
        store_req     = '0;

        // Accesses are sequenced so that no read meets a write to the same entry in one cycle.
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_cmd.kind)
                    KIND_START: begin
                        if (r_running) begin
                            if (is_frame(r_target)) begin
                                store_req.rd_en   = 1'b1;
                                store_req.rd_addr = addr_of(r_target);
                                n_state           = S_SEQ_WB;
                            end else begin
                                n_done  = 1'b1;
                                n_res   = '0;
                                n_state = S_IDLE;
                            end
                        end else begin
                            // Return the stale target before walking the filled list.
                            if (is_frame(r_target)) begin
                                store_req.link_we   = 1'b1;
                                store_req.link_addr = addr_of(r_target);
                                store_req.link_data = r_free_head;
                                n_free_head         = r_target;
                                n_target            = NIL_LINK;
                            end
                            n_cursor   = r_filled_head;
                            n_walk_cnt = '0;
                            n_state    = S_WALK_RD;
                        end
                    end

                    KIND_STOP: begin
                        n_running = 1'b0;
                        n_done    = 1'b1;
                        n_res     = '0;
                        n_state   = S_IDLE;
                    end

                    KIND_CAPTURE: begin
                        if (!r_running) begin
                            n_done       = 1'b1;
                            n_res        = '0;
                            n_res.status = ST_NOT_RUNNING;
                            n_state      = S_IDLE;
                        end else if (!is_frame(r_target)) begin
                            n_done       = 1'b1;
                            n_res        = '0;
                            n_res.status = ST_NO_FRAME;
                            n_state      = S_IDLE;
                        end else begin
                            // Append the finished target; terminate it here, chain the old tail next.
                            store_req.link_we   = 1'b1;
                            store_req.link_addr = addr_of(r_target);
                            store_req.link_data = NIL_LINK;
                            n_filled_tail       = r_target;
                            n_target            = NIL_LINK;
                            n_cursor            = r_filled_tail;
                            n_pop_take          = 1'b0;
                            if (!is_frame(r_filled_head)) begin
                                n_filled_head = r_target;
                                n_state       = S_POP_RD;
                            end else if (is_frame(r_filled_tail)) begin
                                n_state = S_APPEND;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                    end

                    KIND_TAKE: begin
                        if (!is_frame(r_filled_head)) begin
                            n_done       = 1'b1;
                            n_res        = '0;
                            n_res.status = ST_NO_FILLED;
                            n_state      = S_IDLE;
                        end else begin
                            n_pop_take = 1'b1;
                            n_state    = S_POP_RD;
                        end
                    end

                    KIND_RELEASE: begin
                        n_done  = 1'b1;
                        n_res   = '0;
                        n_state = S_IDLE;
                        if (!index_in_pool(r_cmd.frame_index)
                                || !r_held[addr_of(rel_frame)]) begin
                            n_res.status = ST_NO_FRAME;
                        end else begin
                            n_held[addr_of(rel_frame)] = 1'b0;
                            store_req.link_we          = 1'b1;
                            store_req.link_addr        = addr_of(rel_frame);
                            store_req.link_data        = r_free_head;
                            n_free_head                = rel_frame;
                        end
                    end

                    default: begin
                        n_done  = 1'b1;
                        n_res   = '0;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_APPEND: begin
                // r_cursor holds the old tail; r_filled_tail is already the new frame.
                store_req.link_we   = 1'b1;
                store_req.link_addr = addr_of(r_cursor);
                store_req.link_data = r_filled_tail;
                n_state             = S_POP_RD;
            end

            S_WALK_RD: begin
                if (is_frame(r_cursor) && (r_walk_cnt < LINK_W'(NUM_FRAMES))) begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = addr_of(r_cursor);
                    n_state           = S_WALK_WR;
                end else begin
                    n_filled_head = NIL_LINK;
                    n_filled_tail = NIL_LINK;
                    n_seq_cnt     = '0;
                    if (is_frame(r_free_head)) begin
                        n_pop_take = 1'b0;
                        n_state    = S_POP_RD;
                    end else begin
                        n_done       = 1'b1;
                        n_res        = '0;
                        n_res.status = ST_NO_FRAME;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_WALK_WR: begin
                // Push the visited frame and advance to its successor.
                store_req.link_we   = 1'b1;
                store_req.link_addr = addr_of(r_cursor);
                store_req.link_data = r_free_head;
                n_free_head         = r_cursor;
                n_cursor            = rd_link;
                n_walk_cnt          = r_walk_cnt + LINK_W'(1);
                n_state             = S_WALK_RD;
            end

            S_POP_RD: begin
                if (!is_frame(pop_frame)) begin
                    n_done       = 1'b1;
                    n_res        = '0;
                    n_res.status = ST_NO_FRAME;
                    n_state      = S_IDLE;
                end else begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = addr_of(pop_frame);
                    n_pop_filled      = pop_from_filled;
                    n_cursor          = pop_frame;
                    n_state           = S_POP_WB;
                end
            end

            S_POP_WB: begin
                if (r_pop_filled) begin
                    if (is_frame(rd_link)) begin
                        n_filled_head = rd_link;
                    end else begin
                        n_filled_head = NIL_LINK;
                        n_filled_tail = NIL_LINK;
                    end
                end else begin
                    n_free_head = rd_link;
                end
                n_done          = 1'b1;
                n_res           = '0;
                n_res.out_frame = out_frame_of(r_cursor);
                n_state         = S_IDLE;
                if (r_pop_take) begin
                    n_held[addr_of(r_cursor)] = 1'b1;
                    n_res.out_sequence        = rd_seq;
                end else begin
                    store_req.seq_we       = 1'b1;
                    store_req.seq_addr     = addr_of(r_cursor);
                    store_req.seq_data     = r_seq_cnt;
                    n_target               = r_cursor;
                    n_seq_cnt              = r_seq_cnt + SEQ_W'(1);
                    n_running              = 1'b1;
                    n_res.out_sequence     = r_seq_cnt;
                    n_res.overwrote_oldest = r_pop_filled;
                end
            end

            S_SEQ_WB: begin
                n_done             = 1'b1;
                n_res              = '0;
                n_res.out_frame    = out_frame_of(r_target);
                n_res.out_sequence = rd_seq;
                n_state            = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Report the running flag as it stands after the event.
        if (n_done) begin
            n_res.is_running = n_running;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[design/cfpm_checker.sv]
// Port-level checks for the capture frame pool manager, bound to the top level.
module cfpm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input cfpm_pkg::t_res o_res
);
    import cfpm_pkg::*;

    // An accepted transfer always raises busy in the cycle after it.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Results never arrive in consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A result only follows a busy period.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a preceding command");

    // Failed events carry no frame.
    a_fail_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status != ST_OK)) |->
            ((o_res.out_frame == '0) && (o_res.out_sequence == '0)
             && !o_res.overwrote_oldest))
        else $error("failed event reported a frame");

    // Stealing the oldest frame happens only on a successful running capture.
    a_steal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.overwrote_oldest) |->
            ((o_res.status == ST_OK) && o_res.is_running))
        else $error("overwrite flag on a failed or stopped event");

endmodule

bind capture_frame_pool_manager_core cfpm_checker u_cfpm_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the capture frame pool manager: directed table, then random events.
`timescale 1ns / 1ps

module tb;
    import cfpm_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 334;
    localparam int DRAIN_CYCLES    = 32;
    localparam int CYCLE_LIMIT     = 200000;

    // Kinds beyond release are ignored by the block.
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        t_cmd cmd;
        logic typed;
        t_res res;
    } dir_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    // Fixed expectation travelling alongside the command of a directed row.
    logic row_typed     = 1'b0;
    t_res row_typed_res = '0;

    int idle_pct  = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    dir_row_t dir_rows[$];
    t_res     pool_result_q[$];

    // Shadow copy of the pool: links, list heads, target, numbering and consumer holds.
    logic [LINK_W-1:0] pool_link [NUM_FRAMES];
    logic [LINK_W-1:0] pool_free_head;
    logic [LINK_W-1:0] pool_fill_head;
    logic [LINK_W-1:0] pool_fill_tail;
    logic [LINK_W-1:0] pool_target;
    logic [SEQ_W-1:0]  pool_seq_ctr;
    logic [SEQ_W-1:0]  pool_frame_seq [NUM_FRAMES];
    logic              pool_running;
    logic              pool_held [NUM_FRAMES];

    capture_frame_pool_manager_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Pool after reset: every frame on the free list, highest index on top.
    function automatic void pool_reset();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            pool_link[i]      = (i == 0) ? NIL_LINK : LINK_W'(i - 1);
            pool_frame_seq[i] = '0;
            pool_held[i]      = 1'b0;
        end
        pool_free_head = LINK_W'(NUM_FRAMES - 1);
        pool_fill_head = NIL_LINK;
        pool_fill_tail = NIL_LINK;
        pool_target    = NIL_LINK;
        pool_seq_ctr   = '0;
        pool_running   = 1'b0;
    endfunction

    function automatic void free_push(input logic [LINK_W-1:0] f);
        if (f < NIL_LINK) begin
            pool_link[f[FRAME_W-1:0]] = pool_free_head;
            pool_free_head = f;
        end
    endfunction

    // Return the top of the free list, or null when it is empty.
    function automatic logic [LINK_W-1:0] free_pop();
        logic [LINK_W-1:0] f;
        f = pool_free_head;
        if (f < NIL_LINK) begin
            pool_free_head = pool_link[f[FRAME_W-1:0]];
            pool_link[f[FRAME_W-1:0]] = NIL_LINK;
        end
        return f;
    endfunction

    // Return the oldest filled frame, or null when none is waiting.
    function automatic logic [LINK_W-1:0] filled_pop();
        logic [LINK_W-1:0] f;
        f = pool_fill_head;
        if (f < NIL_LINK) begin
            pool_fill_head = pool_link[f[FRAME_W-1:0]];
            if (pool_fill_head >= NIL_LINK) begin
                pool_fill_head = NIL_LINK;
                pool_fill_tail = NIL_LINK;
            end
            pool_link[f[FRAME_W-1:0]] = NIL_LINK;
        end
        return f;
    endfunction

    function automatic void target_assign(input logic [LINK_W-1:0] f);
        pool_target = f;
        pool_frame_seq[f[FRAME_W-1:0]] = pool_seq_ctr;
        pool_seq_ctr = pool_seq_ctr + 1'b1;
    endfunction

    // Apply one event to the shadow pool and return the result the block must give.
    function automatic t_res pool_apply(input t_cmd c);
        t_res              r;
        logic [LINK_W-1:0] f;
        logic [LINK_W-1:0] nx;
        r = '0;
        case (c.kind)
            KIND_START: begin
                if (pool_running) begin
                    if (pool_target < NIL_LINK) begin
                        r.out_frame    = pool_target[2:0];
                        r.out_sequence = pool_frame_seq[pool_target[FRAME_W-1:0]];
                    end
                end else begin
                    // Hand back the stale target and every filled frame, then renumber.
                    free_push(pool_target);
                    pool_target = NIL_LINK;
                    f = pool_fill_head;
                    for (int n = 0; n < NUM_FRAMES && f < NIL_LINK; n++) begin
                        nx = pool_link[f[FRAME_W-1:0]];
                        free_push(f);
                        f = nx;
                    end
                    pool_fill_head = NIL_LINK;
                    pool_fill_tail = NIL_LINK;
                    pool_seq_ctr   = '0;
                    f = free_pop();
                    if (f < NIL_LINK) begin
                        target_assign(f);
                        pool_running   = 1'b1;
                        r.out_frame    = f[2:0];
                        r.out_sequence = pool_frame_seq[f[FRAME_W-1:0]];
                    end else begin
                        r.status = ST_NO_FRAME;
                    end
                end
            end
            KIND_STOP: pool_running = 1'b0;
            KIND_CAPTURE: begin
                if (!pool_running) begin
                    r.status = ST_NOT_RUNNING;
                end else if (pool_target >= NIL_LINK) begin
                    r.status = ST_NO_FRAME;
                end else begin
                    // Append the finished frame behind the filled tail.
                    pool_link[pool_target[FRAME_W-1:0]] = NIL_LINK;
                    if (pool_fill_head >= NIL_LINK) begin
                        pool_fill_head = pool_target;
                    end else if (pool_fill_tail < NIL_LINK) begin
                        pool_link[pool_fill_tail[FRAME_W-1:0]] = pool_target;
                    end
                    pool_fill_tail = pool_target;
                    pool_target    = NIL_LINK;
                    f = free_pop();
                    if (f >= NIL_LINK) begin
                        // Free list exhausted: steal the oldest filled frame.
                        f = filled_pop();
                        r.overwrote_oldest = 1'b1;
                    end
                    if (f >= NIL_LINK) begin
                        r.status           = ST_NO_FRAME;
                        r.overwrote_oldest = 1'b0;
                    end else begin
                        target_assign(f);
                        r.out_frame    = f[2:0];
                        r.out_sequence = pool_frame_seq[f[FRAME_W-1:0]];
                    end
                end
            end
            KIND_TAKE: begin
                f = filled_pop();
                if (f >= NIL_LINK) begin
                    r.status = ST_NO_FILLED;
                end else begin
                    pool_held[f[FRAME_W-1:0]] = 1'b1;
                    r.out_frame    = f[2:0];
                    r.out_sequence = pool_frame_seq[f[FRAME_W-1:0]];
                end
            end
            KIND_RELEASE: begin
                if (c.frame_index >= NUM_FRAMES || !pool_held[c.frame_index]) begin
                    r.status = ST_NO_FRAME;
                end else begin
                    pool_held[c.frame_index] = 1'b0;
                    free_push(LINK_W'(c.frame_index));
                end
            end
            default: ;
        endcase
        r.is_running = pool_running;
        return r;
    endfunction

    // Random event, weighted towards well-formed capture / take / release traffic.
    function automatic t_cmd pick_cmd();
        t_cmd c;
        int   roll;
        int   nheld;
        int   pick;
        c.frame_index = 3'($urandom_range(7, 0));
        roll = $urandom_range(99, 0);
        nheld = 0;
        for (int i = 0; i < NUM_FRAMES; i++) nheld += pool_held[i];
        if (!pool_running && $urandom_range(99, 0) < 35) begin
            c.kind = KIND_START;
        end else if (roll < 40) begin
            c.kind = KIND_CAPTURE;
        end else if (roll < 64) begin
            c.kind = KIND_TAKE;
        end else if (roll < 84) begin
            c.kind = KIND_RELEASE;
            // Mostly hand back a frame the consumer really holds.
            if (nheld > 0 && $urandom_range(99, 0) < 85) begin
                pick = $urandom_range(nheld - 1, 0);
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (pool_held[i]) begin
                        if (pick == 0) c.frame_index = 3'(i);
                        pick--;
                    end
                end
            end
        end else if (roll < 90) begin
            c.kind = KIND_START;
        end else if (roll < 95) begin
            c.kind = KIND_STOP;
        end else begin
            c.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        end
        return c;
    endfunction

    function automatic void dir_add(input logic [2:0] k, input logic [2:0] idx,
                                    input logic typed, input t_res res);
        dir_row_t row;
        row.cmd.kind        = k;
        row.cmd.frame_index = idx;
        row.typed           = typed;
        row.res             = res;
        dir_rows.push_back(row);
    endfunction

    // Offer one command: idle at random first, then hold start until the transfer.
    // Leave start high on return so back-to-back commands need no extra edge.
    task automatic send_cmd(input t_cmd c, input logic typed, input t_res res);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        row_typed     <= typed;
        row_typed_res <= res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Predict on every command transfer; check every strobed result against the oldest
    // prediction. All signals are sampled as they stood before this edge.
    always @(posedge i_clk) begin : monitor
        t_res want;
        t_res got;
        if (i_rst_n) begin
            if (o_done) begin
                got = o_res;
                if (pool_result_q.size() == 0) begin
                    $display("%0t: result with nothing expected: status=%0d frame=%0d seq=%0d",
                             $time, got.status, got.out_frame, got.out_sequence);
                    err_cnt++;
                end else begin
                    want = pool_result_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        err_cnt++;
                    end
                    if (got.out_frame !== want.out_frame) begin
                        $display("%0t: out_frame expected %0d, got %0d",
                                 $time, want.out_frame, got.out_frame);
                        err_cnt++;
                    end
                    if (got.out_sequence !== want.out_sequence) begin
                        $display("%0t: out_sequence expected %0d, got %0d",
                                 $time, want.out_sequence, got.out_sequence);
                        err_cnt++;
                    end
                    if (got.overwrote_oldest !== want.overwrote_oldest) begin
                        $display("%0t: overwrote_oldest expected %0b, got %0b",
                                 $time, want.overwrote_oldest, got.overwrote_oldest);
                        err_cnt++;
                    end
                    if (got.is_running !== want.is_running) begin
                        $display("%0t: is_running expected %0b, got %0b",
                                 $time, want.is_running, got.is_running);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                // Advance the shadow pool always; a directed row may pin the result.
                want = pool_apply(i_cmd);
                if (row_typed) want = row_typed_res;
                pool_result_q.push_back(want);
            end
        end
    end

    // Watchdog: drop out if the run hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd c;
        int   n_items;
        pool_reset();

        // Directed table. Rows with a typed result carry their expected result with
        // them; the rest are left to the shadow pool.
        dir_add(KIND_TAKE,     3'd0, 1'b1, '{ST_NO_FILLED,   3'd0, 32'd0, 1'b0, 1'b0});
        dir_add(KIND_CAPTURE,  3'd0, 1'b1, '{ST_NOT_RUNNING, 3'd0, 32'd0, 1'b0, 1'b0});
        // release of a frame never taken
        dir_add(KIND_RELEASE,  3'd7, 1'b1, '{ST_NO_FRAME,    3'd0, 32'd0, 1'b0, 1'b0});
        dir_add(KIND_STOP,     3'd0, 1'b1, '{ST_OK,          3'd0, 32'd0, 1'b0, 1'b0});
        dir_add(KIND_SPARE_HI, 3'd7, 1'b1, '{ST_OK,          3'd0, 32'd0, 1'b0, 1'b0});
        dir_add(KIND_START,    3'd0, 1'b1, '{ST_OK,          3'd7, 32'd0, 1'b0, 1'b1});
        // start while running reports the current target
        dir_add(KIND_START,    3'd5, 1'b1, '{ST_OK,          3'd7, 32'd0, 1'b0, 1'b1});
        dir_add(KIND_CAPTURE,  3'd0, 1'b1, '{ST_OK,          3'd6, 32'd1, 1'b0, 1'b1});
        // run the free list dry, then force the oldest filled frame to be stolen
        for (int i = 0; i < 7; i++) dir_add(KIND_CAPTURE, 3'(i), 1'b0, '0);
        dir_add(KIND_TAKE,     3'd0, 1'b0, '0);
        dir_add(KIND_TAKE,     3'd7, 1'b0, '0);
        dir_add(KIND_RELEASE,  3'd6, 1'b0, '0);
        // second release of the same frame
        dir_add(KIND_RELEASE,  3'd6, 1'b1, '{ST_NO_FRAME,    3'd0, 32'd0, 1'b0, 1'b1});
        dir_add(KIND_STOP,     3'd0, 1'b1, '{ST_OK,          3'd0, 32'd0, 1'b0, 1'b0});
        dir_add(KIND_CAPTURE,  3'd0, 1'b1, '{ST_NOT_RUNNING, 3'd0, 32'd0, 1'b0, 1'b0});
        // take still works while stopped; restart walks the filled list home
        dir_add(KIND_TAKE,     3'd0, 1'b0, '0);
        dir_add(KIND_START,    3'd0, 1'b0, '0);
        dir_add(KIND_RELEASE,  3'd5, 1'b0, '0);
        dir_add(KIND_TAKE,     3'd0, 1'b1, '{ST_NO_FILLED,   3'd0, 32'd0, 1'b0, 1'b1});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 15;
        foreach (dir_rows[k]) send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].res);

        // Random traffic: light sender gaps, then heavy gaps, then none at all.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
            n_items  = 0;
            while (n_items < ITEMS_PER_PHASE) begin
                c = pick_cmd();
                send_cmd(c, 1'b0, '0);
                if (c.kind <= KIND_RELEASE) n_items++;
            end
        end
        start <= 1'b0;

        // Wait for the outstanding results, then linger for any stray strobe.
        @(posedge i_clk);
        while (pool_result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pool_result_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
